// ===== rtl/mie_pkg.sv =====
// ============================================================================
// Modular inverse engine package
// Shared types and constants for the modular inverse engine.
// ============================================================================
package mie_pkg;

    localparam int WORD_BITS = 64;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CHECK  = 9'b000000010,
        S_DIV    = 9'b000000100,
        S_TEST   = 9'b000001000,
        S_MUL    = 9'b000010000,
        S_RED    = 9'b000100000,
        S_UPDATE = 9'b001000000,
        S_FINAL  = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    localparam logic KIND_MODULUS = 1'b0;
    localparam logic KIND_VALUE   = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_ZERO = 1'b1;

endpackage

// ===== rtl/modular_inverse_engine.sv =====
// ============================================================================
// Modular inverse engine
// Computes value^-1 mod modulus with the extended Euclidean convergent
// recurrence, using one shared shift-subtract divider and a shift-add
// multiplier under a small sequencer.
// ============================================================================
//
// Channel   Direction  Signals
// -------   ---------  --------------------------------------------------
// command   in         i_start, o_busy, i_kind, i_word_index, i_word_data,
//                      i_start_req
// result    out        o_result_valid, o_result_index, o_result_data,
//                      o_last, o_status
//
// A transaction is accepted when i_start is high and o_busy is low. A word
// write alone leaves the engine idle. A start runs per Euclid step one
// bit-serial division and, after the first step, one shift-add multiply and
// one bit-serial reduction (a load, the shift-subtract steps and a finish);
// the number of steps depends on the operands. The result words then leave
// on consecutive cycles, one strobe each; the receiver cannot stall them.
// Reset is synchronous, active low, and clears control state and operands.

module modular_inverse_engine #(
    parameter int OPERAND_BITS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_kind,
    input  logic [1:0]  i_word_index,
    input  logic [63:0] i_word_data,
    input  logic        i_start_req,
    output logic        o_result_valid,
    output logic [1:0]  o_result_index,
    output logic [63:0] o_result_data,
    output logic        o_last,
    output logic        o_status
);
    import mie_pkg::*;

    localparam int N        = OPERAND_BITS;
    localparam int WORDS    = N / WORD_BITS;
    localparam int OUTW     = (WORDS < 4) ? WORDS : 4;
    localparam int CW       = $clog2(3 * N + 2);
    localparam logic [CW-1:0] CNT_N       = CW'(N);
    localparam logic [CW-1:0] CNT_RED_END = CW'(3 * N + 1);
    localparam logic [1:0] LAST_IDX = 2'(OUTW - 1);

    t_state r_state;

    logic [N-1:0]   r_modulus, r_value;
    logic [N-1:0]   r_m, r_n, r_q, r_p0, r_p1, r_res;
    logic [N:0]     r_rem;
    logic [2*N-1:0] r_num;
    logic [2*N-1:0] r_acc;
    logic [N-1:0]   r_mq;
    logic [CW-1:0]  r_cnt;
    logic           r_div_first;
    logic           r_sign;
    logic           r_status;
    logic [1:0]     r_oidx;

    // Shared shift-subtract step: used for Euclid division and reduction.
    logic [N:0]   w_sh;
    logic         w_ge;
    logic [N:0]   w_den;
    assign w_den = r_state == S_DIV ? {1'b0, r_n} : {1'b0, r_modulus};
    assign w_sh  = {r_rem[N-1:0], r_num[2*N-1]};
    assign w_ge  = w_sh >= w_den;

    assign o_busy = r_state != S_IDLE;

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_modulus      <= '0;
            r_value        <= '0;
            r_sign         <= 1'b0;
            r_status       <= STATUS_OK;
            r_oidx         <= '0;
            r_cnt          <= '0;
            r_div_first    <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (32'(i_word_index) < WORDS) begin
                            if (i_kind == KIND_VALUE)
                                r_value[32'(i_word_index)*WORD_BITS +: WORD_BITS]
                                    <= i_word_data;
                            else
                                r_modulus[32'(i_word_index)*WORD_BITS +: WORD_BITS]
                                    <= i_word_data;
                        end
                        if (i_start_req) r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_oidx <= '0;
                    if (r_value == '0 || r_modulus == '0) begin
                        r_status <= STATUS_ZERO;
                        r_res    <= '0;
                        r_state  <= S_OUT;
                    end else begin
                        r_status    <= STATUS_OK;
                        r_sign      <= 1'b0;
                        r_m         <= r_modulus;
                        r_n         <= r_value;
                        r_p0        <= N'(1);
                        r_num       <= {r_modulus, {N{1'b0}}};
                        r_rem       <= '0;
                        r_cnt       <= '0;
                        r_div_first <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_sh - w_den : w_sh;
                    r_num <= r_num << 1;
                    r_q   <= {r_q[N-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_N - 1'b1) r_state <= S_TEST;
                end
                S_TEST: begin
                    if (r_div_first) begin
                        r_p1        <= r_q;
                        r_div_first <= 1'b0;
                        if (r_rem[N-1:0] == '0) r_state <= S_FINAL;
                        else r_state <= S_UPDATE;
                    end else begin
                        // Start q*p1 + p0.
                        r_acc   <= {{N{1'b0}}, r_p0};
                        r_mq    <= r_q;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_UPDATE: begin
                    // Next Euclid step: m = n, n = r.
                    r_sign  <= ~r_sign;
                    r_m     <= r_n;
                    r_n     <= r_rem[N-1:0];
                    r_num   <= {r_n, {N{1'b0}}};
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_MUL: begin
                    if (r_mq[0])
                        r_acc <= r_acc + ({{N{1'b0}}, r_p1} << r_cnt);
                    r_mq  <= r_mq >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_N - 1'b1) begin
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    if (r_cnt == CNT_N) begin
                        r_num <= r_acc;
                        r_rem <= '0;
                    end else if (r_cnt == CNT_RED_END) begin
                        r_p0 <= r_p1;
                        r_p1 <= r_rem[N-1:0];
                        // Remainder of the Euclid division is in r_m slot.
                        r_state <= (r_m == '0) ? S_FINAL : S_UPDATE;
                        r_rem   <= {1'b0, r_m};
                    end else begin
                        r_rem <= w_ge ? w_sh - w_den : w_sh;
                        r_num <= r_num << 1;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_FINAL: begin
                    r_res   <= r_sign ? r_modulus - r_p0 : r_p0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    o_result_valid <= 1'b1;
                    o_result_index <= r_oidx;
                    o_result_data  <= r_res[32'(r_oidx)*WORD_BITS +: WORD_BITS];
                    o_last         <= r_oidx == LAST_IDX;
                    o_status       <= r_status;
                    r_oidx         <= r_oidx + 1'b1;
                    if (r_oidx == LAST_IDX) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // Keep the Euclid remainder across multiply and reduction.
            if (r_state == S_TEST && !r_div_first) r_m <= r_rem[N-1:0];
        end
    end

    // Assertions.
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_last |=> !o_result_valid) else $error("extra word");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_busy || o_last) else $error("result while idle");

endmodule
